// ----- hdl/point_rotate_translate_assert.svh -----
// Assertion macros used by the point_rotate_translate checker.
// No dependencies; included by bare file name.
`ifndef POINT_ROTATE_TRANSLATE_ASSERT_SVH
`define POINT_ROTATE_TRANSLATE_ASSERT_SVH

// ante implies cons, checked at every rising edge outside reset
`define PRT_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// expr must never be true outside reset
`define PRT_ASSERT_NEVER(lbl, clk_s, rst_s, expr, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(expr)) \
        else $error(msg);

`endif

// ----- hdl/prt_pkg.sv -----
// Package for point_rotate_translate: payload types, widths, register indexes
// and the CORDIC arctangent table. No dependencies.
package prt_pkg;

    localparam int COORD_W          = 24;
    localparam int ANGLE_W          = 16;
    localparam int CW               = 32;   // cos/sin, Q30
    localparam int ZW               = 33;   // angle accumulator, 2^-32 turn
    localparam int PROD_W           = COORD_W + CW;
    localparam int SUM_W            = PROD_W + 1;
    localparam int FRAC_SHIFT       = 30;
    localparam int ROT_W            = SUM_W - FRAC_SHIFT;
    localparam int ATAN_COUNT       = 24;
    localparam int DEF_CORDIC_STEPS = 16;
    localparam int CFG_ADDR_W       = 1;

    localparam logic signed [CW-1:0]    INV_GAIN_Q30 = 32'sd652032874;
    localparam logic signed [SUM_W-1:0] ROUND_HALF   = SUM_W'(64'sd536870912);

    localparam logic [CFG_ADDR_W-1:0] REG_BASE_X = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_BASE_Y = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] offset_x;
        logic signed [COORD_W-1:0] offset_y;
        logic        [ANGLE_W-1:0] turn_angle;
    } prt_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] moved_x;
        logic signed [COORD_W-1:0] moved_y;
    } prt_out_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] offset_x;
        logic signed [COORD_W-1:0] offset_y;
    } prt_ofs_t;

    // CORDIC result handed to the multiply stages
    typedef struct packed {
        logic                 valid;
        logic signed [CW-1:0] cos_q;
        logic signed [CW-1:0] sin_q;
        prt_ofs_t             ofs;
    } prt_trig_t;

    // atan(2^-i) in units of 2^-32 turn, rounded
    function automatic logic [CW-1:0] prt_atan(input logic [4:0] idx);
        logic [CW-1:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/prt_cordic.sv -----
// Pipelined rotation-mode CORDIC: quadrant fold, one stage per iteration,
// sign fix-up. Carries the offsets alongside. Depends on prt_pkg.
module prt_cordic
    import prt_pkg::*;
#(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [ANGLE_W-1:0] angle,
    input  prt_ofs_t           in_ofs,
    output prt_trig_t          trig
);

    logic                 valid_reg [0:CORDIC_STEPS];
    logic                 flip_reg  [0:CORDIC_STEPS];
    logic signed [CW-1:0] x_reg     [0:CORDIC_STEPS];
    logic signed [CW-1:0] y_reg     [0:CORDIC_STEPS];
    logic signed [ZW-1:0] z_reg     [0:CORDIC_STEPS];
    prt_ofs_t             ofs_reg   [0:CORDIC_STEPS];

    logic signed [CW-1:0] x_next    [1:CORDIC_STEPS];
    logic signed [CW-1:0] y_next    [1:CORDIC_STEPS];
    logic signed [ZW-1:0] z_next    [1:CORDIC_STEPS];

    logic signed [ANGLE_W:0] a_ext;
    logic signed [ANGLE_W:0] a_red;
    logic                    flip_next;
    logic signed [ZW-1:0]    z0_next;

    logic                 out_valid_reg;
    logic signed [CW-1:0] cos_reg;
    logic signed [CW-1:0] sin_reg;
    prt_ofs_t             out_ofs_reg;

    // fold into [-quarter, +quarter] turn; negate the result when folded
    always_comb
    begin
        a_ext     = $signed({angle[ANGLE_W-1], angle});
        a_red     = a_ext;
        flip_next = 1'b0;
        if (a_ext > 17'sd16384)
        begin
            a_red     = a_ext - 17'sd32768;
            flip_next = 1'b1;
        end
        else if (a_ext < -17'sd16384)
        begin
            a_red     = a_ext + 17'sd32768;
            flip_next = 1'b1;
        end
        z0_next = $signed({a_red, 16'b0});
    end

    always_comb
    begin
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (!z_reg[i][ZW-1])
            begin
                x_next[i+1] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] - $signed({1'b0, prt_atan(5'(i))});
            end
            else
            begin
                x_next[i+1] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] + $signed({1'b0, prt_atan(5'(i))});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= CORDIC_STEPS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
            out_valid_reg <= valid_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= INV_GAIN_Q30;
        y_reg[0]    <= '0;
        z_reg[0]    <= z0_next;
        flip_reg[0] <= flip_next;
        ofs_reg[0]  <= in_ofs;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            x_reg[i+1]    <= x_next[i+1];
            y_reg[i+1]    <= y_next[i+1];
            z_reg[i+1]    <= z_next[i+1];
            flip_reg[i+1] <= flip_reg[i];
            ofs_reg[i+1]  <= ofs_reg[i];
        end
        cos_reg     <= flip_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
        sin_reg     <= flip_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];
        out_ofs_reg <= ofs_reg[CORDIC_STEPS];
    end

    assign trig.valid = out_valid_reg;
    assign trig.cos_q = cos_reg;
    assign trig.sin_q = sin_reg;
    assign trig.ofs   = out_ofs_reg;

endmodule

// ----- hdl/point_rotate_translate.sv -----
// Top level: base point registers, CORDIC pipeline, multiply, round and
// saturate stages. Depends on prt_pkg and prt_cordic.
//
//  channel   handshake            payload
//  input     start / busy         operands (prt_in_t)
//  result    result_valid         result   (prt_out_t)
//  config    cfg_wr               cfg_addr, cfg_data
//
// One transaction is taken every cycle; busy stays low.
// Pipeline registers in order: fold, one stage per CORDIC iteration,
// sign fix-up, multiply, round, offset add with saturation.
// rst_n clears the valid bits and the base point; payload is not reset.
// The receiver cannot stall, so the pipeline never holds.
module point_rotate_translate
    import prt_pkg::*;
#(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  prt_in_t               operands,
    output logic                  result_valid,
    output prt_out_t              result,
    input  logic                  cfg_wr,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [COORD_W-1:0]    cfg_data
);

    logic signed [COORD_W-1:0] base_x_reg;
    logic signed [COORD_W-1:0] base_y_reg;

    prt_ofs_t  in_ofs;
    prt_trig_t trig;

    logic                     va_reg;
    logic signed [PROD_W-1:0] pxc_reg, pys_reg, pyc_reg, pxs_reg;
    prt_ofs_t                 ofa_reg;

    logic                     vb_reg;
    logic signed [SUM_W-1:0]  sum_x_next, sum_y_next;
    logic signed [ROT_W-1:0]  rx_reg, ry_reg;
    prt_ofs_t                 ofb_reg;

    logic                     vc_reg;
    logic signed [COORD_W-1:0] mx_reg, my_reg;

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [COORD_W-1:0] ofs,
        input logic signed [ROT_W-1:0]   rot
    );
        logic signed [ROT_W:0] s;
        logic signed [COORD_W-1:0] r;
        s = (ROT_W+1)'(ofs) + (ROT_W+1)'(rot);
        if (s > (ROT_W+1)'(32'sd8388607))
            r = 24'sh7FFFFF;
        else if (s < (ROT_W+1)'(-32'sd8388608))
            r = 24'sh800000;
        else
            r = COORD_W'(s);
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_x_reg <= '0;
            base_y_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_addr)
                REG_BASE_X: base_x_reg <= $signed(cfg_data);
                REG_BASE_Y: base_y_reg <= $signed(cfg_data);
                default:    ;
            endcase
        end
    end

    assign in_ofs.offset_x = operands.offset_x;
    assign in_ofs.offset_y = operands.offset_y;

    prt_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .angle    (operands.turn_angle),
        .in_ofs   (in_ofs),
        .trig     (trig)
    );

    // Q8 * Q30 -> Q38, then round to Q8
    always_comb
    begin
        sum_x_next = SUM_W'(pxc_reg) - SUM_W'(pys_reg) + ROUND_HALF;
        sum_y_next = SUM_W'(pyc_reg) + SUM_W'(pxs_reg) + ROUND_HALF;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= trig.valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pxc_reg <= PROD_W'(base_x_reg) * PROD_W'($signed(trig.cos_q));
        pys_reg <= PROD_W'(base_y_reg) * PROD_W'($signed(trig.sin_q));
        pyc_reg <= PROD_W'(base_y_reg) * PROD_W'($signed(trig.cos_q));
        pxs_reg <= PROD_W'(base_x_reg) * PROD_W'($signed(trig.sin_q));
        ofa_reg <= trig.ofs;

        rx_reg  <= ROT_W'(sum_x_next >>> FRAC_SHIFT);
        ry_reg  <= ROT_W'(sum_y_next >>> FRAC_SHIFT);
        ofb_reg <= ofa_reg;

        mx_reg  <= sat_coord(ofb_reg.offset_x, rx_reg);
        my_reg  <= sat_coord(ofb_reg.offset_y, ry_reg);
    end

    assign busy           = 1'b0;
    assign result_valid   = vc_reg;
    assign result.moved_x = mx_reg;
    assign result.moved_y = my_reg;

endmodule

// ----- hdl/prt_checker.sv -----
// Port-level checks for point_rotate_translate, bound to the top level.
// Depends on prt_pkg and point_rotate_translate_assert.svh.
`include "point_rotate_translate_assert.svh"

module prt_checker
    import prt_pkg::*;
#(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
)
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic result_valid
);

    localparam int LATENCY = CORDIC_STEPS + 5;

    logic accept;
    assign accept = start && !busy;

    `PRT_ASSERT_NEVER(a_never_busy, clk, rst_n, busy, "busy raised by pipeline")
    `PRT_ASSERT_IMP(a_result_follows, clk, rst_n, accept, ##LATENCY result_valid, "transaction lost")
    `PRT_ASSERT_IMP(a_no_phantom, clk, rst_n, result_valid, $past(accept && rst_n, LATENCY), "result without transaction")

endmodule

bind point_rotate_translate prt_checker #(
    .CORDIC_STEPS (CORDIC_STEPS)
) u_prt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid)
);

// ----- tb/tb_point_rotate_translate.sv -----
// Testbench for point_rotate_translate: directed and random points checked
// against an in-bench CORDIC rotate/translate predictor. Depends on prt_pkg.
`timescale 1ns / 100ps

module tb_point_rotate_translate;
    import prt_pkg::*;

    localparam int STEPS          = 16;
    localparam int LATENCY        = STEPS + 5;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_PHASES  = 9;
    localparam int PHASE_ITEMS    = 105;

    localparam longint INV_GAIN = 64'sd652032874;
    localparam longint SAT_HI   = 64'sd8388607;
    localparam longint SAT_LO   = -64'sd8388608;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

    // atan(2^-i) in 2^-32 turn
    localparam longint ATAN_TURN [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    localparam logic [ANGLE_W-1:0] EDGE_ANGLES [11] = '{
        16'd0, 16'd16383, 16'd16384, 16'd16385, 16'd32767, 16'd32768,
        16'd32769, 16'd49151, 16'd49152, 16'd49153, 16'd65535
    };

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  start    = 1'b0;
    logic                  busy;
    prt_in_t               operands = '0;
    logic                  result_valid;
    prt_out_t              result;
    logic                  cfg_wr   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = REG_BASE_X;
    logic [COORD_W-1:0]    cfg_data = '0;

    // base point as the block should hold it
    logic signed [COORD_W-1:0] base_x_q = '0;
    logic signed [COORD_W-1:0] base_y_q = '0;

    prt_out_t pending_moves [$];
    int       sender_idle_pct = 0;
    int       error_count     = 0;
    int       mismatch_count  = 0;
    int       points_sent     = 0;
    int       moves_checked   = 0;
    int       base_writes     = 0;
    int       quiet_cycles    = 0;

    point_rotate_translate #(.CORDIC_STEPS(STEPS)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operands     (operands),
        .result_valid (result_valid),
        .result       (result),
        .cfg_wr       (cfg_wr),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic longint clamp24(input longint v);
        if (v > SAT_HI)
            return SAT_HI;
        if (v < SAT_LO)
            return SAT_LO;
        return v;
    endfunction

    function automatic void cordic_trig(input logic [ANGLE_W-1:0] ang,
                                        output longint cos_q, output longint sin_q);
        longint a;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     flip;
        a    = longint'($signed(ang));
        flip = 1'b0;
        // fold into [-quarter, +quarter] turn, negate at the end
        if (a > 16384) begin
            a    = a - 32768;
            flip = 1'b1;
        end
        else if (a < -16384) begin
            a    = a + 32768;
            flip = 1'b1;
        end
        z = a * 65536;
        x = INV_GAIN;
        y = 0;
        for (int i = 0; i < STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TURN[i];
            end
            else begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TURN[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        cos_q = x;
        sin_q = y;
    endfunction

    function automatic prt_out_t predict_move(input prt_in_t p);
        prt_out_t m;
        longint   c;
        longint   s;
        longint   bx;
        longint   by;
        longint   rx;
        longint   ry;
        cordic_trig(p.turn_angle, c, s);
        bx = longint'(base_x_q);
        by = longint'(base_y_q);
        rx = (bx * c - by * s + (64'sd1 <<< 29)) >>> 30;
        ry = (by * c + bx * s + (64'sd1 <<< 29)) >>> 30;
        m.moved_x = COORD_W'(clamp24(longint'(p.offset_x) + rx));
        m.moved_y = COORD_W'(clamp24(longint'(p.offset_y) + ry));
        return m;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        logic signed [COORD_W-1:0] v;
        case ($urandom_range(7))
            0:       v = COORD_MAX;
            1:       v = COORD_MIN;
            2, 3:    v = COORD_W'(int'($urandom_range(8191)) - 4096);
            default: v = COORD_W'($urandom);
        endcase
        return v;
    endfunction

    function automatic prt_in_t rand_point();
        prt_in_t p;
        p.offset_x = rand_coord();
        p.offset_y = rand_coord();
        if ($urandom_range(7) == 0)
            p.turn_angle = EDGE_ANGLES[$urandom_range(10)];
        else
            p.turn_angle = ANGLE_W'($urandom);
        return p;
    endfunction

    // one input transaction; returns at the edge that accepted it, start left high
    task automatic send_point(input prt_in_t p);
        // each cycle idles with the set chance
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start    <= 1'b1;
        operands <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_moves.push_back(predict_move(p));
        points_sent++;
    endtask

    task automatic send_fields(input logic signed [COORD_W-1:0] ox,
                               input logic signed [COORD_W-1:0] oy,
                               input logic [ANGLE_W-1:0] ang);
        prt_in_t p;
        p.offset_x   = ox;
        p.offset_y   = oy;
        p.turn_angle = ang;
        send_point(p);
    endtask

    // drop start and let the pipeline drain
    task automatic drain_pipeline();
        start <= 1'b0;
        @(posedge clk);
        while (pending_moves.size() != 0)
            @(posedge clk);
    endtask

    // only called with the pipeline empty
    task automatic write_base(input logic signed [COORD_W-1:0] bx,
                              input logic signed [COORD_W-1:0] by);
        cfg_wr   <= 1'b1;
        cfg_addr <= REG_BASE_X;
        cfg_data <= bx;
        @(posedge clk);
        cfg_addr <= REG_BASE_Y;
        cfg_data <= by;
        @(posedge clk);
        cfg_wr   <= 1'b0;
        base_x_q = bx;
        base_y_q = by;
        base_writes += 2;
        @(posedge clk);
    endtask

    task automatic test_reset_base();
        // base is zero out of reset, so the result is just the offset
        send_fields(COORD_MAX, COORD_MIN, 16'd12345);
        send_fields(COORD_MIN, COORD_MAX, 16'd40000);
        send_fields('0, '0, 16'd0);
        send_fields(-24'sd1, 24'sd1, 16'd65535);
        drain_pipeline();
    endtask

    task automatic test_quadrant_folding();
        write_base(24'sd25600, -24'sd9600);
        foreach (EDGE_ANGLES[i])
            send_fields(24'sd256, -24'sd512, EDGE_ANGLES[i]);
        send_fields('0, '0, 16'd1);
        send_fields('0, '0, 16'd8192);
        send_fields('0, '0, 16'd24576);
        drain_pipeline();
    endtask

    task automatic test_saturation();
        write_base(COORD_MAX, COORD_MAX);
        send_fields(COORD_MAX, COORD_MAX, 16'd0);
        send_fields(COORD_MIN, COORD_MIN, 16'd32768);
        drain_pipeline();
        write_base(COORD_MIN, COORD_MIN);
        send_fields(COORD_MIN, COORD_MIN, 16'd0);
        send_fields(COORD_MAX, COORD_MAX, 16'd32768);
        drain_pipeline();
        write_base(COORD_MAX, COORD_MIN);
        send_fields(COORD_MAX, COORD_MIN, 16'd8192);
        send_fields(COORD_MIN, COORD_MAX, 16'd40960);
        drain_pipeline();
    endtask

    task automatic test_random_traffic();
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        int pause_at;
        for (int k = 0; k < RANDOM_PHASES; k++) begin
            case (k / 3)
                0:       sender_idle_pct = 23;
                1:       sender_idle_pct = 51;
                default: sender_idle_pct = 0;
            endcase
            case (k % 3)
                0: begin
                    bx = COORD_W'($urandom);
                    by = COORD_W'($urandom);
                end
                1: begin
                    bx = ($urandom_range(1)) ? COORD_MAX : COORD_MIN;
                    by = ($urandom_range(1)) ? COORD_MAX : COORD_MIN;
                end
                default: begin
                    bx = COORD_W'(int'($urandom_range(8191)) - 4096);
                    by = COORD_W'(int'($urandom_range(8191)) - 4096);
                end
            endcase
            write_base(bx, by);
            pause_at = $urandom_range(10, PHASE_ITEMS - 10);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_point(rand_point());
                // let the pipeline run dry mid-phase now and then
                if (n == pause_at || $urandom_range(79) == 0)
                    drain_pipeline();
            end
            drain_pipeline();
        end
    endtask

    always @(posedge clk) begin
        prt_out_t want;
        if (rst_n && result_valid) begin
            if (pending_moves.size() == 0) begin
                error_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result x=%0d y=%0d", result.moved_x, result.moved_y);
            end
            else begin
                want = pending_moves.pop_front();
                moves_checked++;
                if (result.moved_x !== want.moved_x || result.moved_y !== want.moved_y) begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch #%0d: moved_x exp %0d got %0d, moved_y exp %0d got %0d",
                                 moves_checked, want.moved_x, result.moved_x,
                                 want.moved_y, result.moved_y);
                end
            end
        end
    end

    // no transaction on either side for too long ends the run
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || result_valid)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[point_rotate_translate] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_base();
        test_quadrant_folding();
        test_saturation();
        test_random_traffic();
        drain_pipeline();
        repeat (LATENCY + 4) @(posedge clk);
        if (pending_moves.size() != 0) begin
            error_count += pending_moves.size();
            $display("%0d results never arrived", pending_moves.size());
        end
        $display("covered %0d points, %0d results checked, %0d base writes, %0d errors",
                 points_sent, moves_checked, base_writes, error_count);
        $display("quadrant folds, saturation at both rails, sender gaps of 23%% and 51%% and none");
        if (error_count == 0)
            $display("[point_rotate_translate] OK");
        else
            $display("[point_rotate_translate] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/prt_pkg.sv
hdl/prt_cordic.sv
hdl/point_rotate_translate.sv
hdl/prt_checker.sv
tb/tb_point_rotate_translate.sv
